/* hw/rtl/fifo_page_replacement_defines.svh */
// Assertion macros for the page replacement block.
`ifndef FIFO_PAGE_REPLACEMENT_DEFINES_SVH
`define FIFO_PAGE_REPLACEMENT_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define FPR_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("page replacement check failed");

// Next-cycle implication, checked while out of reset.
`define FPR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("page replacement check failed");

`endif

/* hw/rtl/fpr_pkg.sv */
// ---------------------------------------------------------------------------
// fpr_pkg
// Shared types and constants of the FIFO page replacement block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fpr_pkg;

   localparam int CFG_BITS       = 5;
   localparam int PORT_PAGE_BITS = 16;
   localparam int SLOT_OUT_BITS  = 4;
   localparam int COUNT_BITS     = 32;

   localparam logic [CFG_BITS-1:0]   CFG_RESET = 5'd16;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = 32'hFFFF_FFFF;

   typedef enum logic [2:0] {
      ST_IDLE    = 3'b001,
      ST_MATCH   = 3'b010,
      ST_RESOLVE = 3'b100
   } fpr_state_type;

   typedef struct packed {
      logic load_page;
      logic compare;
      logic resolve;
      logic csr_write;
   } fpr_cmd_type;

endpackage

`default_nettype wire

/* hw/rtl/fpr_ctrl.sv */
// ---------------------------------------------------------------------------
// fpr_ctrl
// Request sequencer: accept, compare, resolve, and response handshake.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fpr_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_stall,
   output      logic               rsp_valid,
   input  wire logic               rsp_stall,
   input  wire logic               csr_valid,
   output      fpr_pkg::fpr_cmd_type cmd
);

   fpr_pkg::fpr_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;
   logic accept;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == fpr_pkg::ST_IDLE) ||
                        ((state_ff == fpr_pkg::ST_RESOLVE) && out_free));
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      cmd           = '0;
      cmd.load_page = accept;
      cmd.csr_write = csr_valid;
      unique case (state_ff)
         fpr_pkg::ST_IDLE: begin
            if (accept) state_in = fpr_pkg::ST_MATCH;
         end
         fpr_pkg::ST_MATCH: begin
            cmd.compare = 1'b1;
            state_in    = fpr_pkg::ST_RESOLVE;
         end
         fpr_pkg::ST_RESOLVE: begin
            if (out_free) begin
               cmd.resolve  = 1'b1;
               rsp_valid_in = 1'b1;
               // take the next word while this one finishes
               state_in     = accept ? fpr_pkg::ST_MATCH : fpr_pkg::ST_IDLE;
            end
         end
         default: state_in = fpr_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fpr_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/fpr_datapath.sv */
// ---------------------------------------------------------------------------
// fpr_datapath
// Frame store, tag compare, victim pointer, counters and response register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fpr_datapath #(
   parameter int FRAME_SLOTS = 16,
   parameter int PAGE_BITS   = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire fpr_pkg::fpr_cmd_type                  cmd,
   input  wire logic [fpr_pkg::PORT_PAGE_BITS-1:0]    req_page_number,
   input  wire logic [fpr_pkg::CFG_BITS-1:0]          csr_data,
   output      logic                                  rsp_hit,
   output      logic [fpr_pkg::SLOT_OUT_BITS-1:0]     rsp_frame_slot,
   output      logic [fpr_pkg::COUNT_BITS-1:0]        rsp_hit_total,
   output      logic [fpr_pkg::COUNT_BITS-1:0]        rsp_fault_total
);

   localparam int SW = $clog2(FRAME_SLOTS);
   localparam int NW = $clog2(FRAME_SLOTS + 1);

   logic [PAGE_BITS-1:0]            frame_page_ff [FRAME_SLOTS];
   logic [FRAME_SLOTS-1:0]          frame_valid_ff;
   logic [SW-1:0]                   victim_ff, victim_in;
   logic [fpr_pkg::COUNT_BITS-1:0]  hit_cnt_ff, hit_cnt_in;
   logic [fpr_pkg::COUNT_BITS-1:0]  fault_cnt_ff, fault_cnt_in;
   logic [fpr_pkg::CFG_BITS-1:0]    cfg_ff;
   logic [PAGE_BITS-1:0]            page_ff;
   logic [FRAME_SLOTS-1:0]          match_ff, match_in;
   logic                            rsp_hit_ff;
   logic [fpr_pkg::SLOT_OUT_BITS-1:0] rsp_frame_slot_ff;
   logic [fpr_pkg::COUNT_BITS-1:0]  rsp_hit_total_ff;
   logic [fpr_pkg::COUNT_BITS-1:0]  rsp_fault_total_ff;

   logic [PAGE_BITS-1:0]            page_in;
   logic [NW-1:0]                   active_n;
   logic [31:0]                     cfg_wide;
   logic                            found;
   logic [SW-1:0]                   hit_slot;
   logic [SW-1:0]                   victim_sel;
   logic [SW-1:0]                   slot_sel;
   logic [31:0]                     slot_wide;

   // keep the low PAGE_BITS bits of the requested page
   always_comb begin
      logic [fpr_pkg::PORT_PAGE_BITS+31:0] wide;
      wide    = {32'b0, req_page_number};
      page_in = wide[PAGE_BITS-1:0];
   end

   // clamp the frame count to 1..FRAME_SLOTS
   assign cfg_wide = {{(32 - fpr_pkg::CFG_BITS){1'b0}}, cfg_ff};
   always_comb begin
      logic [31:0] slots_wide;
      slots_wide = 32'(FRAME_SLOTS);
      priority if (cfg_ff == '0) active_n = NW'(1);
      else if (cfg_wide > slots_wide) active_n = slots_wide[NW-1:0];
      else active_n = cfg_wide[NW-1:0];
   end

   always_comb begin
      for (int i = 0; i < FRAME_SLOTS; i++) begin
         match_in[i] = frame_valid_ff[i] && (frame_page_ff[i] == page_ff) &&
                       (32'(i) < {{(32 - NW){1'b0}}, active_n});
      end
   end

   // lowest matching frame wins
   always_comb begin
      found    = |match_ff;
      hit_slot = '0;
      for (int i = FRAME_SLOTS - 1; i >= 0; i--) begin
         if (match_ff[i]) hit_slot = SW'(i);
      end
   end

   always_comb begin
      logic [31:0] v_wide, n_wide;
      n_wide     = {{(32 - NW){1'b0}}, active_n};
      v_wide     = {{(32 - SW){1'b0}}, victim_ff};
      victim_sel = (v_wide < n_wide) ? victim_ff : '0;
      v_wide     = {{(32 - SW){1'b0}}, victim_sel} + 32'd1;
      victim_in  = (v_wide >= n_wide) ? '0 : v_wide[SW-1:0];
   end

   assign slot_sel     = found ? hit_slot : victim_sel;
   assign slot_wide    = {{(32 - SW){1'b0}}, slot_sel};
   assign hit_cnt_in   = (hit_cnt_ff == fpr_pkg::COUNT_MAX) ? hit_cnt_ff
                                                            : hit_cnt_ff + 32'd1;
   assign fault_cnt_in = (fault_cnt_ff == fpr_pkg::COUNT_MAX) ? fault_cnt_ff
                                                              : fault_cnt_ff + 32'd1;

   assign rsp_hit         = rsp_hit_ff;
   assign rsp_frame_slot  = rsp_frame_slot_ff;
   assign rsp_hit_total   = rsp_hit_total_ff;
   assign rsp_fault_total = rsp_fault_total_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_valid_ff <= '0;
         victim_ff      <= '0;
         hit_cnt_ff     <= '0;
         fault_cnt_ff   <= '0;
         cfg_ff         <= fpr_pkg::CFG_RESET;
      end else begin
         if (cmd.csr_write) cfg_ff <= csr_data;
         if (cmd.resolve) begin
            if (found) begin
               hit_cnt_ff <= hit_cnt_in;
            end else begin
               frame_valid_ff[victim_sel] <= 1'b1;
               victim_ff                  <= victim_in;
               fault_cnt_ff               <= fault_cnt_in;
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_page) page_ff <= page_in;
      if (cmd.compare) match_ff <= match_in;
      if (cmd.resolve) begin
         if (!found) frame_page_ff[victim_sel] <= page_ff;
         rsp_hit_ff         <= found;
         rsp_frame_slot_ff  <= slot_wide[fpr_pkg::SLOT_OUT_BITS-1:0];
         rsp_hit_total_ff   <= found ? hit_cnt_in : hit_cnt_ff;
         rsp_fault_total_ff <= found ? fault_cnt_ff : fault_cnt_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/fifo_page_replacement.sv */
// ---------------------------------------------------------------------------
// fifo_page_replacement
// Fully associative page frame store with first-in-first-out replacement.
// ---------------------------------------------------------------------------
// Each request word passes the MATCH and RESOLVE states: MATCH compares the
// page against every frame and registers the match vector; RESOLVE picks the
// lowest matching frame (or the round-robin victim on a fault) and updates
// the store, counters and response register. The next request is accepted
// in RESOLVE once the response register is free, overlapping the last one.
// Responses sit in an output register, so a stalled response blocks only
// once the next result is ready. Frame valid bits clear at reset. csr_data
// sets the frame count (1..FRAME_SLOTS, zero acts as one); the user must
// write it only while idle, as the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module fifo_page_replacement #(
   parameter int FRAME_SLOTS = 16,
   parameter int PAGE_BITS   = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output      logic                               req_stall,
   input  wire logic [fpr_pkg::PORT_PAGE_BITS-1:0] req_page_number,
   output      logic                               rsp_valid,
   input  wire logic                               rsp_stall,
   output      logic                               rsp_hit,
   output      logic [fpr_pkg::SLOT_OUT_BITS-1:0]  rsp_frame_slot,
   output      logic [fpr_pkg::COUNT_BITS-1:0]     rsp_hit_total,
   output      logic [fpr_pkg::COUNT_BITS-1:0]     rsp_fault_total,
   input  wire logic                               csr_valid,
   output      logic                               csr_ready,
   input  wire logic [fpr_pkg::CFG_BITS-1:0]       csr_data
);

   fpr_pkg::fpr_cmd_type cmd;

   assign csr_ready = 1'b1;

   fpr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .csr_valid (csr_valid),
      .cmd       (cmd)
   );

   fpr_datapath #(
      .FRAME_SLOTS (FRAME_SLOTS),
      .PAGE_BITS   (PAGE_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_page_number (req_page_number),
      .csr_data        (csr_data),
      .rsp_hit         (rsp_hit),
      .rsp_frame_slot  (rsp_frame_slot),
      .rsp_hit_total   (rsp_hit_total),
      .rsp_fault_total (rsp_fault_total)
   );

endmodule

`default_nettype wire

/* hw/rtl/fpr_checker.sv */
// ---------------------------------------------------------------------------
// fpr_checker
// Port-level checks of the page replacement block, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "fifo_page_replacement_defines.svh"

module fpr_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_valid,
   input wire logic                              req_stall,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_stall,
   input wire logic                              rsp_hit,
   input wire logic [fpr_pkg::SLOT_OUT_BITS-1:0] rsp_frame_slot,
   input wire logic [fpr_pkg::COUNT_BITS-1:0]    rsp_hit_total,
   input wire logic [fpr_pkg::COUNT_BITS-1:0]    rsp_fault_total
);

   // hold a stalled response word
   `FPR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_hit) && $stable(rsp_frame_slot) && $stable(rsp_hit_total) && $stable(rsp_fault_total))
   // an accepted request is compared before the next can enter
   `FPR_ASSERT_NEXT(a_req_gap, clock, reset, req_valid && !req_stall, req_stall)
   // a hit is already counted in the total it reports
   `FPR_ASSERT_IMPLY(a_hit_count, clock, reset, rsp_valid && rsp_hit, rsp_hit_total != '0)
   // so is a fault
   `FPR_ASSERT_IMPLY(a_fault_count, clock, reset, rsp_valid && !rsp_hit, rsp_fault_total != '0)

endmodule

bind fifo_page_replacement fpr_checker u_fpr_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_hit         (rsp_hit),
   .rsp_frame_slot  (rsp_frame_slot),
   .rsp_hit_total   (rsp_hit_total),
   .rsp_fault_total (rsp_fault_total)
);

`default_nettype wire

/* sim/fifo_page_replacement_check.sv */
// ---------------------------------------------------------------------------
// fifo_page_replacement_check
// Watches the request, response and csr channels of the page replacement
// block, keeps its own copy of the frame store, and checks every response
// word against the oldest outstanding prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fifo_page_replacement_check (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic [fpr_pkg::PORT_PAGE_BITS-1:0] req_page_number,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic                               rsp_hit,
   input  logic [fpr_pkg::SLOT_OUT_BITS-1:0]  rsp_frame_slot,
   input  logic [fpr_pkg::COUNT_BITS-1:0]     rsp_hit_total,
   input  logic [fpr_pkg::COUNT_BITS-1:0]     rsp_fault_total,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [fpr_pkg::CFG_BITS-1:0]       csr_data,
   output int                                 mismatches,
   output int                                 outstanding
);

   localparam int SLOTS = 16;

   typedef struct packed {
      logic                               hit;
      logic [fpr_pkg::SLOT_OUT_BITS-1:0]  slot;
      logic [fpr_pkg::COUNT_BITS-1:0]     hit_total;
      logic [fpr_pkg::COUNT_BITS-1:0]     fault_total;
   } page_result_t;

   page_result_t                       awaited_results[$];
   logic [fpr_pkg::PORT_PAGE_BITS-1:0] resident_page[SLOTS];
   logic [SLOTS-1:0]                   resident_valid;
   logic [3:0]                         victim;
   logic [fpr_pkg::COUNT_BITS-1:0]     hits;
   logic [fpr_pkg::COUNT_BITS-1:0]     faults;
   logic [fpr_pkg::CFG_BITS-1:0]       frame_count;

   initial begin
      mismatches  = 0;
      outstanding = 0;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatches < 100)
         $display("mismatch %s: got %0h, want %0h at %0t ns", what, got, want, $time);
      mismatches++;
   endtask

   always @(posedge clock) begin : track
      page_result_t want;
      page_result_t next;
      int unsigned  active;
      int unsigned  pick;
      logic         found;

      if (reset) begin
         awaited_results.delete();
         resident_valid = '0;
         victim         = '0;
         hits           = '0;
         faults         = '0;
         frame_count    = fpr_pkg::CFG_RESET;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               report_mismatch("response word with no request", 0, 0);
            end else begin
               want = awaited_results.pop_front();
               if (rsp_hit !== want.hit)
                  report_mismatch("hit", rsp_hit, want.hit);
               if (rsp_frame_slot !== want.slot)
                  report_mismatch("frame_slot", rsp_frame_slot, want.slot);
               if (rsp_hit_total !== want.hit_total)
                  report_mismatch("hit_total", rsp_hit_total, want.hit_total);
               if (rsp_fault_total !== want.fault_total)
                  report_mismatch("fault_total", rsp_fault_total, want.fault_total);
            end
         end

         if (csr_valid && csr_ready)
            frame_count = csr_data;

         if (req_valid && !req_stall) begin
            // zero acts as one frame, anything past the store saturates
            if (frame_count == 0)
               active = 1;
            else if (frame_count > SLOTS)
               active = SLOTS;
            else
               active = frame_count;

            found = 1'b0;
            pick  = 0;
            for (int i = 0; i < active; i++) begin
               if (!found && resident_valid[i] && resident_page[i] == req_page_number) begin
                  found = 1'b1;
                  pick  = i;
               end
            end

            if (found) begin
               if (hits != fpr_pkg::COUNT_MAX)
                  hits = hits + 1'b1;
            end else begin
               // a stale pointer past the frame count restarts at frame 0
               pick = (victim < active) ? victim : 0;
               resident_page[pick]  = req_page_number;
               resident_valid[pick] = 1'b1;
               victim = (pick + 1 >= active) ? 4'd0 : 4'(pick + 1);
               if (faults != fpr_pkg::COUNT_MAX)
                  faults = faults + 1'b1;
            end

            next.hit         = found;
            next.slot        = pick[3:0];
            next.hit_total   = hits;
            next.fault_total = faults;
            awaited_results.push_back(next);
         end
      end
      outstanding = awaited_results.size();
   end

endmodule

/* sim/fifo_page_replacement_test.sv */
// ---------------------------------------------------------------------------
// fifo_page_replacement_test
// Drives page requests and frame count writes into the page replacement
// block under random sender and receiver idling; the checker beside the
// block predicts every response and counts mismatches.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fifo_page_replacement_test;

   localparam int QUIET_LIMIT  = 4000;
   localparam int SEGMENTS     = 12;
   localparam int SEGMENT_REQS = 142;

   logic                               clock           = 1'b0;
   logic                               reset           = 1'b1;
   logic                               req_valid       = 1'b0;
   logic                               req_stall;
   logic [fpr_pkg::PORT_PAGE_BITS-1:0] req_page_number = '0;
   logic                               rsp_valid;
   logic                               rsp_stall       = 1'b0;
   logic                               rsp_hit;
   logic [fpr_pkg::SLOT_OUT_BITS-1:0]  rsp_frame_slot;
   logic [fpr_pkg::COUNT_BITS-1:0]     rsp_hit_total;
   logic [fpr_pkg::COUNT_BITS-1:0]     rsp_fault_total;
   logic                               csr_valid       = 1'b0;
   logic                               csr_ready;
   logic [fpr_pkg::CFG_BITS-1:0]       csr_data        = '0;

   int mismatches;
   int outstanding;
   int send_idle_pct = 34;
   int recv_idle_pct = 65;

   always #6 clock = ~clock;

   fifo_page_replacement u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_page_number (req_page_number),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_hit         (rsp_hit),
      .rsp_frame_slot  (rsp_frame_slot),
      .rsp_hit_total   (rsp_hit_total),
      .rsp_fault_total (rsp_fault_total),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data)
   );

   fifo_page_replacement_check u_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_page_number (req_page_number),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_hit         (rsp_hit),
      .rsp_frame_slot  (rsp_frame_slot),
      .rsp_hit_total   (rsp_hit_total),
      .rsp_fault_total (rsp_fault_total),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data),
      .mismatches      (mismatches),
      .outstanding     (outstanding)
   );

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
   end

   // end the run after too many cycles without any accepted word
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("FAIL fifo_page_replacement");
      $finish;
   end

   task automatic send_page(input logic [fpr_pkg::PORT_PAGE_BITS-1:0] page);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_page_number <= page;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // hold until every response word has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      @(posedge clock);
   endtask

   task automatic write_frame_count(input logic [fpr_pkg::CFG_BITS-1:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      logic [fpr_pkg::CFG_BITS-1:0]       setting;
      logic [fpr_pkg::PORT_PAGE_BITS-1:0] base;
      int                                 active;
      int                                 span;
      logic [fpr_pkg::CFG_BITS-1:0]       fixed_settings[6];

      fixed_settings = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd2, 5'd17};

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // fill, hit at both page extremes
      write_frame_count(5'd16);
      send_page(16'h0000);
      send_page(16'hFFFF);
      send_page(16'h0000);
      send_page(16'hFFFF);
      send_page(16'h5555);
      send_page(16'hAAAA);
      send_page(16'h0001);
      send_page(16'h8000);

      // shrink below the victim pointer: victim restarts at frame 0
      write_frame_count(5'd2);
      send_page(16'h5555);
      send_page(16'h5555);

      // grow again: two frames now hold the same page, lowest wins
      write_frame_count(5'd16);
      send_page(16'h5555);
      send_page(16'hAAAA);

      // zero frames acts as one
      write_frame_count(5'd0);
      send_page(16'h0007);
      send_page(16'h0007);
      send_page(16'h0008);
      send_page(16'h8000);

      // count past the store saturates
      write_frame_count(5'd31);
      send_page(16'h8000);
      send_page(16'h0001);

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         setting = (seg < 6) ? fixed_settings[seg] : 5'($urandom_range(0, 31));
         write_frame_count(setting);
         case (seg / 4)
            0: begin
               send_idle_pct = 34;
               recv_idle_pct <= 65;
            end
            1: begin
               send_idle_pct = 65;
               recv_idle_pct <= 34;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct <= 0;
            end
         endcase

         active = (setting == 0) ? 1 : ((setting > 16) ? 16 : setting);
         base   = 16'($urandom_range(0, 65535));
         span   = active + $urandom_range(0, 4);
         for (int k = 0; k < SEGMENT_REQS; k++) begin
            // mostly a working set near the frame count, some wide noise
            if ($urandom_range(0, 99) < 75)
               send_page(base + 16'($urandom_range(0, span)));
            else
               send_page(16'($urandom_range(0, 65535)));
         end
      end

      wait_drained();
      repeat (16) @(posedge clock);
      if (mismatches == 0)
         $display("PASS fifo_page_replacement");
      else
         $display("FAIL fifo_page_replacement");
      $finish;
   end

endmodule
